/* src/i2cw_pkg.sv */
`timescale 1ns / 1ps

package i2cw_pkg;

    // Message codes on the input channel
    typedef enum logic [1:0] {
        ACT_SELECT = 2'd0,
        ACT_MODE   = 2'd1,
        ACT_WRITE  = 2'd2
    } action_t;

    // Bus symbol codes on the output channel
    typedef enum logic [2:0] {
        SYM_START   = 3'd0,
        SYM_RESTART = 3'd1,
        SYM_STOP    = 3'd2,
        SYM_BIT     = 3'd3,
        SYM_ACK     = 3'd4
    } sym_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_COMMAND_CTRL   = 2'd1;
    localparam logic [1:0] CFG_DATA_CTRL      = 2'd2;

    // Configuration reset values
    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'h3c;
    localparam logic [7:0] COMMAND_CTRL_RST   = 8'h00;
    localparam logic [7:0] DATA_CTRL_RST      = 8'h40;

    // Job queue depth between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        action_t    action;
        logic [7:0] value;
    } in_item_t;

    typedef struct packed {
        sym_t       symbol;
        logic       bit_value;
        logic       last;
    } out_item_t;

    // Work handed from front to back
    typedef enum logic [1:0] {
        JOB_STOP   = 2'd0,
        JOB_HEADER = 2'd1,
        JOB_DATA   = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic       restart;
        logic [7:0] addr_byte;
        logic [7:0] ctrl_byte;
        logic [7:0] data_byte;
    } job_t;

endpackage

/* src/i2cw_front.sv */
`timescale 1ns / 1ps

module i2cw_front
    import i2cw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       job_valid,
    input  logic       job_ready,
    output job_t       job
);

    logic [6:0] dev_addr_reg;
    logic [7:0] cmd_ctrl_reg;
    logic [7:0] dat_ctrl_reg;

    logic bus_started_reg, bus_started_next;
    logic data_mode_reg,   data_mode_next;
    logic hdr_pend_reg,    hdr_pend_next;

    logic accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = job_ready;
    assign accept    = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= DEVICE_ADDRESS_RST;
            cmd_ctrl_reg <= COMMAND_CTRL_RST;
            dat_ctrl_reg <= DATA_CTRL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS: dev_addr_reg <= cfg_data[6:0];
                CFG_COMMAND_CTRL:   cmd_ctrl_reg <= cfg_data;
                CFG_DATA_CTRL:      dat_ctrl_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Classify the message, update link state, build the job
    always_comb
    begin
        bus_started_next = bus_started_reg;
        data_mode_next   = data_mode_reg;
        hdr_pend_next    = hdr_pend_reg;
        job_valid        = 1'b0;
        job.kind         = JOB_DATA;
        job.restart      = bus_started_reg;
        job.addr_byte    = {dev_addr_reg, 1'b0};
        job.ctrl_byte    = data_mode_reg ? dat_ctrl_reg : cmd_ctrl_reg;
        job.data_byte    = in_item.value;
        if (in_valid)
        begin
            unique case (in_item.action)
                ACT_SELECT:
                begin
                    data_mode_next = 1'b0;
                    hdr_pend_next  = 1'b1;
                    if (in_item.value == 8'd0)
                    begin
                        job_valid        = 1'b1;
                        job.kind         = JOB_STOP;
                        bus_started_next = 1'b0;
                    end
                end
                ACT_MODE:
                begin
                    data_mode_next = (in_item.value != 8'd0);
                    hdr_pend_next  = 1'b1;
                end
                ACT_WRITE:
                begin
                    job_valid = 1'b1;
                    if (hdr_pend_reg)
                    begin
                        job.kind         = JOB_HEADER;
                        bus_started_next = 1'b1;
                        hdr_pend_next    = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_started_reg <= 1'b0;
            data_mode_reg   <= 1'b0;
            hdr_pend_reg    <= 1'b0;
        end
        else if (accept)
        begin
            bus_started_reg <= bus_started_next;
            data_mode_reg   <= data_mode_next;
            hdr_pend_reg    <= hdr_pend_next;
        end
    end

endmodule

/* src/i2cw_fifo.sv */
`timescale 1ns / 1ps

module i2cw_fifo
    import i2cw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/i2cw_back.sv */
`timescale 1ns / 1ps

module i2cw_back
    import i2cw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEAD,
        ST_BITS,
        ST_STOP
    } state_t;

    state_t      state_reg;
    logic        restart_reg;
    logic [23:0] bytes_reg;
    logic [3:0]  bit_cnt_reg;
    logic [1:0]  bytes_left_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic advance, gen, final_sym, load;

    // Output register moves when empty or being taken
    assign advance   = !out_valid_reg || out_ready;
    assign gen       = advance && (state_reg != ST_IDLE);
    assign final_sym = (state_reg == ST_STOP) ||
                       ((state_reg == ST_BITS) && (bit_cnt_reg == 4'd8) &&
                        (bytes_left_reg == 2'd0));
    assign job_ready = (state_reg == ST_IDLE) || (gen && final_sym);
    assign load      = job_valid && job_ready;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Symbol sequencer with registered output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            restart_reg    <= 1'b0;
            bytes_reg      <= '0;
            bit_cnt_reg    <= '0;
            bytes_left_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '{symbol: SYM_STOP, bit_value: 1'b0, last: 1'b0};
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= gen;
            end

            // emit one symbol
            if (gen)
            begin
                unique case (state_reg)
                    ST_LEAD:
                    begin
                        out_reg.symbol    <= restart_reg ? SYM_RESTART : SYM_START;
                        out_reg.bit_value <= 1'b0;
                        out_reg.last      <= 1'b0;
                        state_reg         <= ST_BITS;
                    end
                    ST_BITS:
                    begin
                        if (bit_cnt_reg == 4'd8)
                        begin
                            out_reg.symbol    <= SYM_ACK;
                            out_reg.bit_value <= 1'b0;
                            out_reg.last      <= (bytes_left_reg == 2'd0);
                            if (bytes_left_reg == 2'd0)
                            begin
                                if (!load)
                                begin
                                    state_reg <= ST_IDLE;
                                end
                            end
                            else
                            begin
                                bit_cnt_reg    <= '0;
                                bytes_left_reg <= bytes_left_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            out_reg.symbol    <= SYM_BIT;
                            out_reg.bit_value <= bytes_reg[23];
                            out_reg.last      <= 1'b0;
                            bytes_reg         <= {bytes_reg[22:0], 1'b0};
                            bit_cnt_reg       <= bit_cnt_reg + 1'b1;
                        end
                    end
                    ST_STOP:
                    begin
                        out_reg.symbol    <= SYM_STOP;
                        out_reg.bit_value <= 1'b0;
                        out_reg.last      <= 1'b1;
                        if (!load)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    default: ;
                endcase
            end

            // load the next job; may come with the final symbol of the current one
            if (load)
            begin
                restart_reg <= job.restart;
                bit_cnt_reg <= '0;
                unique case (job.kind)
                    JOB_STOP:
                    begin
                        state_reg <= ST_STOP;
                    end
                    JOB_HEADER:
                    begin
                        state_reg      <= ST_LEAD;
                        bytes_reg      <= {job.addr_byte, job.ctrl_byte, job.data_byte};
                        bytes_left_reg <= 2'd2;
                    end
                    default:
                    begin
                        state_reg      <= ST_BITS;
                        bytes_reg      <= {job.data_byte, 16'd0};
                        bytes_left_reg <= 2'd0;
                    end
                endcase
            end
        end
    end

endmodule

/* src/i2c_display_command_data_writer_top.sv */
`timescale 1ns / 1ps
// A write is registered in the job queue, then in the serializer's output register.
// The serializer gives one bus symbol per cycle while out_ready holds; a write is 9
// symbols, or 28 when it carries the start, address and control byte header.
// Select and mode messages set link state; a deselect adds one stop symbol.
// Reset (rst_n, asynchronous, active low) clears the link state and job queue
// and loads address 0x3c, command control 0x00 and data control 0x40.

module i2c_display_command_data_writer_top
    import i2cw_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic front_valid, front_ready;
    job_t front_job;
    logic back_valid, back_ready;
    job_t back_job;

    // Message decode and link state
    i2cw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    // Job queue
    i2cw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    // Bus symbol serializer
    i2cw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

/* tb/i2c_display_command_data_writer_top_test.sv */
`timescale 1ns / 1ps

module i2c_display_command_data_writer_top_test;
    import i2cw_pkg::*;

    localparam int SETTLE_CYCLES  = 10;    // quiet time before a register write
    localparam int TAIL_CYCLES    = 40;    // extra cycles after the last symbol
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all
    localparam int PRINT_CAP      = 40;    // mismatch lines printed at most
    localparam int PHASE_ITEMS    = 70;    // random messages per register setting
    localparam int NUM_PHASES     = 4;

    // Kinds of work for the driver
    typedef enum logic [1:0] {
        OP_MSG   = 2'd0,
        OP_REG   = 2'd1,
        OP_DRAIN = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        in_item_t   msg;
        logic [1:0] reg_idx;
        logic [7:0] reg_val;
    } op_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    in_item_t   in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    // Pending work and expected bus symbols
    op_t        pend_q[$];
    out_item_t  sym_expect_q[$];

    // Predictor copy of link state and registers
    logic       bus_on   = 1'b0;
    logic       data_sel = 1'b0;
    logic       hdr_due  = 1'b0;
    logic [6:0] dev_addr = DEVICE_ADDRESS_RST;
    logic [7:0] cmd_ctrl = COMMAND_CTRL_RST;
    logic [7:0] dat_ctrl = DATA_CTRL_RST;

    // Handshake flags from the last rising edge, used by the driver
    logic       in_acc    = 1'b0;
    logic       cfg_acc   = 1'b0;
    int         quiet_cnt = 0;
    int         idle_cnt  = 0;
    int         err_cnt   = 0;

    // Sender burst shaping and receiver stall pattern
    int          burst_left = 1;
    int          gap_left   = 0;
    logic [15:0] stall_pat  = 16'hFFFF;
    logic [3:0]  stall_pos  = '0;

    i2c_display_command_data_writer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    task automatic flag_error(input string what);
        if (err_cnt < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, what);
        err_cnt++;
    endtask

    task automatic push_sym(input sym_t s, input logic b, input logic fin);
        out_item_t e;
        e.symbol    = s;
        e.bit_value = b;
        e.last      = fin;
        sym_expect_q.push_back(e);
    endtask

    // Eight data bits MSB first, then the ack slot
    task automatic push_byte(input logic [7:0] b, input logic fin);
        for (int i = 7; i >= 0; i--)
            push_sym(SYM_BIT, b[i], 1'b0);
        push_sym(SYM_ACK, 1'b0, fin);
    endtask

    // Bus symbols caused by one accepted message
    task automatic predict_symbols(input in_item_t m);
        case (m.action)
            ACT_SELECT:
            begin
                data_sel = 1'b0;
                hdr_due  = 1'b1;
                if (m.value == 8'd0)
                begin
                    push_sym(SYM_STOP, 1'b0, 1'b1);
                    bus_on = 1'b0;
                end
            end
            ACT_MODE:
            begin
                data_sel = (m.value != 8'd0);
                hdr_due  = 1'b1;
            end
            ACT_WRITE:
            begin
                if (hdr_due)
                begin
                    push_sym(bus_on ? SYM_RESTART : SYM_START, 1'b0, 1'b0);
                    bus_on = 1'b1;
                    push_byte({dev_addr, 1'b0}, 1'b0);
                    push_byte(data_sel ? dat_ctrl : cmd_ctrl, 1'b0);
                    hdr_due = 1'b0;
                end
                push_byte(m.value, 1'b1);
            end
            default: ;  // unused code, ignored
        endcase
    endtask

    task automatic queue_msg(input action_t a, input logic [7:0] v);
        op_t op;
        op         = '0;
        op.kind    = OP_MSG;
        op.msg.action = a;
        op.msg.value  = v;
        pend_q.push_back(op);
    endtask

    task automatic queue_reg(input logic [1:0] idx, input logic [7:0] v);
        op_t op;
        op         = '0;
        op.kind    = OP_REG;
        op.reg_idx = idx;
        op.reg_val = v;
        pend_q.push_back(op);
    endtask

    task automatic queue_drain();
        op_t op;
        op      = '0;
        op.kind = OP_DRAIN;
        pend_q.push_back(op);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Register value: low end, high end or anything in between
    function automatic logic [7:0] pick_reg(input logic [7:0] hi);
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return hi;
        return 8'($urandom_range(0, hi));
    endfunction

    // Driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        op_t        op;
        logic       nxt_iv;
        logic       nxt_cv;
        logic       nxt_rdy;
        in_item_t   nxt_item;
        logic [1:0] nxt_idx;
        logic [7:0] nxt_data;
        nxt_iv   = in_valid;
        nxt_cv   = cfg_valid;
        nxt_item = in_item;
        nxt_idx  = cfg_index;
        nxt_data = cfg_data;
        nxt_rdy  = out_ready;
        if (rst_n)
        begin
            if (in_valid && in_acc)
                nxt_iv = 1'b0;
            if (cfg_valid && cfg_acc)
                nxt_cv = 1'b0;
            if (!nxt_iv && !nxt_cv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pend_q.size() > 0)
                begin
                    op = pend_q[0];
                    case (op.kind)
                        OP_MSG:
                        begin
                            nxt_iv   = 1'b1;
                            nxt_item = op.msg;
                            void'(pend_q.pop_front());
                            if (burst_left <= 1)
                            begin
                                burst_left = $urandom_range(1, 12);
                                gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                         : $urandom_range(1, 6);
                            end
                            else
                                burst_left--;
                        end
                        OP_REG:
                        begin
                            // only once the block has gone quiet
                            if (sym_expect_q.size() == 0 && quiet_cnt >= SETTLE_CYCLES)
                            begin
                                nxt_cv   = 1'b1;
                                nxt_idx  = op.reg_idx;
                                nxt_data = op.reg_val;
                                void'(pend_q.pop_front());
                            end
                        end
                        default:
                        begin
                            if (sym_expect_q.size() == 0)
                                void'(pend_q.pop_front());
                        end
                    endcase
                end
            end

            // receiver stalls follow a fresh 16-bit pattern
            if (stall_pos == 4'd0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pat = 16'hFFFF;
                    1: stall_pat = 16'($urandom);
                    2: stall_pat = 16'($urandom) | 16'($urandom);
                    default: stall_pat = 16'h8000;
                endcase
            end
            nxt_rdy   = stall_pat[stall_pos];
            stall_pos = stall_pos + 4'd1;
        end
        in_valid  <= nxt_iv;
        in_item   <= nxt_item;
        cfg_valid <= nxt_cv;
        cfg_index <= nxt_idx;
        cfg_data  <= nxt_data;
        out_ready <= nxt_rdy;
    end

    // Monitor: predict on accepted messages, check each accepted symbol
    always @(posedge clk)
    begin
        out_item_t want;
        logic      any_hs;
        if (!rst_n)
        begin
            bus_on   = 1'b0;
            data_sel = 1'b0;
            hdr_due  = 1'b0;
            dev_addr = DEVICE_ADDRESS_RST;
            cmd_ctrl = COMMAND_CTRL_RST;
            dat_ctrl = DATA_CTRL_RST;
            in_acc    <= 1'b0;
            cfg_acc   <= 1'b0;
            quiet_cnt <= 0;
            idle_cnt  <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_symbols(in_item);

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEVICE_ADDRESS: dev_addr = cfg_data[6:0];
                    CFG_COMMAND_CTRL:   cmd_ctrl = cfg_data;
                    CFG_DATA_CTRL:      dat_ctrl = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (sym_expect_q.size() == 0)
                    flag_error($sformatf("unexpected symbol %0d", out_item.symbol));
                else
                begin
                    want = sym_expect_q.pop_front();
                    if (out_item.symbol !== want.symbol)
                        flag_error($sformatf("symbol %0d, want %0d",
                                             out_item.symbol, want.symbol));
                    if (out_item.bit_value !== want.bit_value)
                        flag_error($sformatf("bit_value %b, want %b",
                                             out_item.bit_value, want.bit_value));
                    if (out_item.last !== want.last)
                        flag_error($sformatf("last %b, want %b",
                                             out_item.last, want.last));
                end
            end

            if ((in_valid && in_ready) || sym_expect_q.size() != 0)
                quiet_cnt <= 0;
            else if (quiet_cnt < SETTLE_CYCLES)
                quiet_cnt <= quiet_cnt + 1;

            in_acc  <= in_valid && in_ready;
            cfg_acc <= cfg_valid && cfg_ready;

            // watchdog on cycles with no handshake
            any_hs = (in_valid && in_ready) || (out_valid && out_ready)
                     || (cfg_valid && cfg_ready);
            if (any_hs)
                idle_cnt <= 0;
            else if (idle_cnt + 1 >= WATCHDOG_LIMIT)
            begin
                $display("i2c_display_command_data_writer_top_test: errors");
                $finish;
            end
            else
                idle_cnt <= idle_cnt + 1;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int cnt;
        int a;
        // directed: write before any select carries no header
        queue_msg(ACT_WRITE, 8'h00);
        queue_msg(ACT_WRITE, 8'hFF);
        queue_msg(ACT_MODE, 8'h01);
        queue_msg(ACT_WRITE, 8'hA5);          // start, data control byte
        queue_msg(ACT_MODE, 8'h00);
        queue_msg(ACT_WRITE, 8'h5A);          // repeated start, command
        queue_msg(ACT_SELECT, 8'hFF);
        queue_msg(ACT_WRITE, 8'h80);
        queue_msg(ACT_SELECT, 8'h00);         // stop
        queue_msg(ACT_SELECT, 8'h00);         // stop on an idle bus
        queue_msg(ACT_WRITE, 8'h01);
        queue_msg(action_t'(2'd3), 8'hFF);    // unused code
        queue_msg(action_t'(2'd3), 8'h00);
        queue_msg(ACT_MODE, 8'h80);
        queue_msg(ACT_WRITE, 8'h7F);
        queue_msg(ACT_WRITE, 8'h55);
        queue_reg(CFG_DEVICE_ADDRESS, 8'd127);
        queue_reg(CFG_COMMAND_CTRL, 8'hFF);
        queue_reg(CFG_DATA_CTRL, 8'h00);
        queue_msg(ACT_MODE, 8'h01);
        queue_msg(ACT_WRITE, 8'hC3);
        queue_msg(ACT_MODE, 8'h00);
        queue_msg(ACT_WRITE, 8'h3C);
        queue_reg(CFG_DEVICE_ADDRESS, 8'd0);
        queue_reg(CFG_COMMAND_CTRL, 8'h00);
        queue_reg(CFG_DATA_CTRL, 8'hFF);
        queue_msg(ACT_SELECT, 8'h01);
        queue_msg(ACT_MODE, 8'hFF);
        queue_msg(ACT_WRITE, 8'h96);
        queue_msg(ACT_SELECT, 8'h00);

        // random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            queue_reg(CFG_DEVICE_ADDRESS, pick_reg(8'd127));
            queue_reg(CFG_COMMAND_CTRL, pick_reg(8'hFF));
            queue_reg(CFG_DATA_CTRL, pick_reg(8'hFF));
            cnt = 0;
            while (cnt < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 70)
                begin
                    // well-formed: select, then mode and writes
                    queue_msg(ACT_SELECT, 8'($urandom_range(1, 255)));
                    cnt++;
                    repeat ($urandom_range(1, 3))
                    begin
                        queue_msg(ACT_MODE, ($urandom_range(0, 1) == 1)
                                            ? 8'($urandom_range(1, 255)) : 8'h00);
                        cnt++;
                        repeat ($urandom_range(1, 5))
                        begin
                            queue_msg(ACT_WRITE, pick_byte());
                            cnt++;
                        end
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        queue_msg(ACT_SELECT, 8'h00);
                        cnt++;
                    end
                end
                else
                begin
                    a = $urandom_range(0, 3);
                    queue_msg(action_t'(a[1:0]), pick_byte());
                    if (a != 3)
                        cnt++;
                end
                if (cnt >= PHASE_ITEMS / 2 && cnt < PHASE_ITEMS / 2 + 8)
                    queue_drain();
            end
        end

        // reset, released on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || in_valid || cfg_valid)
            @(posedge clk);
        while (sym_expect_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sym_expect_q.size() != 0)
            flag_error("symbols still expected at end of run");

        if (err_cnt == 0)
            $display("i2c_display_command_data_writer_top_test: clean");
        else
            $display("i2c_display_command_data_writer_top_test: errors");
        $finish;
    end

endmodule
